@@ hw/rtl/static_nat_rule_table_macros.svh @@
// ---------------------------------------------------------------------------
// static NAT rule table assertion macros
// shared concurrent check shorthands, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef STATIC_NAT_RULE_TABLE_MACROS_SVH
`define STATIC_NAT_RULE_TABLE_MACROS_SVH

// same-cycle implication
`define SNRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("snrt same-cycle check failed");

// next-cycle implication
`define SNRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("snrt next-cycle check failed");

`endif

@@ hw/rtl/snrt_pkg.sv @@
// ---------------------------------------------------------------------------
// snrt_pkg
// types, codes and helpers shared by the static NAT rule table
// ---------------------------------------------------------------------------
package snrt_pkg;

  localparam int unsigned MaxRulesDef = 64;
  localparam int unsigned TotalW      = 7;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [2:0] {
    ACT_OUTBOUND = 3'd0,
    ACT_INBOUND  = 3'd1,
    ACT_ADD      = 3'd2,
    ACT_DELETE   = 3'd3,
    ACT_MODIFY   = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_NO_RULE = 2'd1,
    STS_FULL    = 2'd2,
    STS_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    PI_ZERO,
    PI_COUNT,
    PI_SEL_NEXT
  } ptr_init_e;

  // one rule as held in memory, en[0] tcp, en[1] udp
  typedef struct packed {
    logic [31:0] in_addr;
    logic [15:0] in_port;
    logic [31:0] out_addr;
    logic [15:0] out_port;
    logic [1:0]  en;
  } rule_t;

  // controller to datapath
  typedef struct packed {
    logic      capture;
    logic      res_init;
    status_e   status;
    logic      walk_init;
    ptr_init_e ptr_init;
    logic      walk_step;
    logic      res_hit;
    logic      wr_rule;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    act_e act;
    logic full;
    logic sel_none;
    logic scan_hit;
    logic walk_end;
  } sts_t;

  function automatic logic proto_ok(input logic [7:0] proto, input logic [1:0] en);
    logic ok;
    ok = 1'b0;
    if (proto == PROTO_TCP) ok = en[0];
    else if (proto == PROTO_UDP) ok = en[1];
    return ok;
  endfunction

endpackage

@@ hw/rtl/snrt_ram.sv @@
// ---------------------------------------------------------------------------
// snrt_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module snrt_ram import snrt_pkg::*; #(
  parameter int unsigned Width = $bits(rule_t),
  parameter int unsigned Depth = MaxRulesDef,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/snrt_datapath.sv @@
// ---------------------------------------------------------------------------
// snrt_datapath
// item registers, rule memory, walk pointer, match logic and result registers
// ---------------------------------------------------------------------------
module snrt_datapath import snrt_pkg::*; #(
  parameter int unsigned MaxRules = MaxRulesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [2:0]        action_i,
  input  logic signed [15:0] position_i,
  input  logic [7:0]        protocol_i,
  input  logic [31:0]       packet_addr_i,
  input  logic [15:0]       packet_port_i,
  input  logic [31:0]       inside_addr_i,
  input  logic [15:0]       inside_port_i,
  input  logic [31:0]       outside_addr_i,
  input  logic [15:0]       outside_port_i,
  input  logic              allow_tcp_i,
  input  logic              allow_udp_i,
  output logic              translated_o,
  output logic [31:0]       result_addr_o,
  output logic [15:0]       result_port_o,
  output logic [1:0]        status_o,
  output logic [TotalW-1:0] rule_total_o
);

  localparam int unsigned IdxW = (MaxRules > 1) ? $clog2(MaxRules) : 1;
  localparam int unsigned CntW = $clog2(MaxRules + 1);
  localparam int unsigned CmpW = (CntW > 15) ? CntW + 1 : 16;

  // captured item
  act_e        act_q;
  logic [15:0] pos_q;
  logic [7:0]  proto_q;
  logic [31:0] paddr_q;
  logic [15:0] pport_q;
  rule_t       rule_q;

  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic            pend_q;
  logic [IdxW-1:0] wa_q;

  logic        res_hit_q;
  logic [31:0] res_addr_q;
  logic [15:0] res_port_q;
  status_e     res_status_q;

  logic [31:0]       out_addr_q;
  logic [15:0]       out_port_q;
  logic [1:0]        out_status_q;
  logic              out_hit_q;
  logic [TotalW-1:0] out_total_q;

  // position resolution
  logic [CmpW-1:0] pos_mag, cnt_ext;
  logic            sel_none;
  logic [CntW-1:0] sel_idx, at_idx;

  always_comb begin
    pos_mag  = CmpW'(pos_q[14:0]);
    cnt_ext  = CmpW'(cnt_q);
    sel_none = 1'b0;
    sel_idx  = '0;
    priority if (cnt_q == '0) begin
      sel_none = 1'b1;
    end else if (pos_q[15] || pos_mag <= CmpW'(1)) begin
      sel_idx = '0;
    end else if (pos_mag <= cnt_ext) begin
      sel_idx = CntW'(pos_mag - CmpW'(1));
    end else begin
      sel_none = 1'b1;
    end
    at_idx = sel_none ? '0 : sel_idx + CntW'(1);
  end

  // walk over the memory, down for insert, up for scan and delete
  logic            walk_down, rd_go, rd_en, shift_we, ram_we;
  logic [CntW-1:0] ptr_dec;
  logic [IdxW-1:0] rd_addr, ram_waddr;
  rule_t           ram_wdata, ram_rdata;
  logic            match;

  assign walk_down = (act_q == ACT_ADD);
  assign ptr_dec   = ptr_q - CntW'(1);
  assign rd_go     = walk_down ? (ptr_q > at_idx) : (ptr_q < cnt_q);
  assign rd_addr   = walk_down ? ptr_dec[IdxW-1:0] : ptr_q[IdxW-1:0];
  assign rd_en     = cmd_i.walk_step && rd_go;
  assign shift_we  = pend_q && cmd_i.walk_step && (act_q == ACT_ADD || act_q == ACT_DELETE);

  always_comb begin
    ram_we    = cmd_i.wr_rule || shift_we;
    ram_waddr = wa_q;
    ram_wdata = ram_rdata;
    if (cmd_i.wr_rule) begin
      ram_waddr = walk_down ? at_idx[IdxW-1:0] : sel_idx[IdxW-1:0];
      ram_wdata = rule_q;
    end
  end

  snrt_ram #(
    .Width($bits(rule_t)),
    .Depth(MaxRules)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    match = 1'b0;
    if (proto_ok(proto_q, ram_rdata.en)) begin
      if (act_q == ACT_OUTBOUND) begin
        match = (ram_rdata.in_addr == paddr_q) && (ram_rdata.in_port == pport_q);
      end else begin
        match = (ram_rdata.out_addr == paddr_q) && (ram_rdata.out_port == pport_q);
      end
    end
  end

  always_comb begin
    unique case (cmd_i.ptr_init)
      PI_ZERO:     ptr_d = '0;
      PI_COUNT:    ptr_d = cnt_q;
      PI_SEL_NEXT: ptr_d = at_idx;
      default:     ptr_d = '0;
    endcase
  end

  assign sts_o.act      = act_q;
  assign sts_o.full     = (cnt_q == CntW'(MaxRules));
  assign sts_o.sel_none = sel_none;
  assign sts_o.scan_hit = pend_q && match;
  assign sts_o.walk_end = !pend_q && !rd_go;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ptr_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + CntW'(1);
      else if (cmd_i.cnt_dec) cnt_q <= cnt_q - CntW'(1);
      if (cmd_i.walk_init) begin
        ptr_q  <= ptr_d;
        pend_q <= 1'b0;
      end else if (cmd_i.walk_step) begin
        pend_q <= rd_go;
        if (rd_go) ptr_q <= walk_down ? ptr_dec : ptr_q + CntW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q           <= act_e'(action_i);
      pos_q           <= position_i;
      proto_q         <= protocol_i;
      paddr_q         <= packet_addr_i;
      pport_q         <= packet_port_i;
      rule_q.in_addr  <= inside_addr_i;
      rule_q.in_port  <= inside_port_i;
      rule_q.out_addr <= outside_addr_i;
      rule_q.out_port <= outside_port_i;
      rule_q.en       <= {allow_udp_i, allow_tcp_i};
    end
    if (cmd_i.walk_step && rd_go) begin
      wa_q <= walk_down ? ptr_q[IdxW-1:0] : ptr_dec[IdxW-1:0];
    end
    if (cmd_i.res_init) begin
      res_hit_q    <= 1'b0;
      res_status_q <= cmd_i.status;
      if (act_q == ACT_OUTBOUND || act_q == ACT_INBOUND) begin
        res_addr_q <= paddr_q;
        res_port_q <= pport_q;
      end else begin
        res_addr_q <= '0;
        res_port_q <= '0;
      end
    end else if (cmd_i.res_hit) begin
      res_hit_q <= 1'b1;
      if (act_q == ACT_OUTBOUND) begin
        res_addr_q <= ram_rdata.out_addr;
        res_port_q <= ram_rdata.out_port;
      end else begin
        res_addr_q <= ram_rdata.in_addr;
        res_port_q <= ram_rdata.in_port;
      end
    end
    if (cmd_i.out_load) begin
      out_hit_q    <= res_hit_q;
      out_addr_q   <= res_addr_q;
      out_port_q   <= res_port_q;
      out_status_q <= res_status_q;
      out_total_q  <= TotalW'(cnt_q);
    end
  end

  assign translated_o  = out_hit_q;
  assign result_addr_o = out_addr_q;
  assign result_port_o = out_port_q;
  assign status_o      = out_status_q;
  assign rule_total_o  = out_total_q;

endmodule

@@ hw/rtl/snrt_ctrl.sv @@
// ---------------------------------------------------------------------------
// snrt_ctrl
// sequencer for lookup scans, insert and delete shifts, and result hand-off
// ---------------------------------------------------------------------------
module snrt_ctrl import snrt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.res_init = 1'b1;
        unique case (sts_i.act)
          ACT_OUTBOUND, ACT_INBOUND: begin
            cmd_o.walk_init = 1'b1;
            cmd_o.ptr_init  = PI_ZERO;
            state_d         = S_SCAN;
          end
          ACT_ADD: begin
            if (sts_i.full) begin
              cmd_o.status = STS_FULL;
              state_d      = S_FINISH;
            end else begin
              cmd_o.walk_init = 1'b1;
              cmd_o.ptr_init  = PI_COUNT;
              state_d         = S_SHIFT;
            end
          end
          ACT_DELETE: begin
            if (sts_i.sel_none) begin
              cmd_o.status = STS_NO_RULE;
              state_d      = S_FINISH;
            end else begin
              cmd_o.walk_init = 1'b1;
              cmd_o.ptr_init  = PI_SEL_NEXT;
              state_d         = S_SHIFT;
            end
          end
          ACT_MODIFY: begin
            if (sts_i.sel_none) begin
              cmd_o.status = STS_NO_RULE;
            end else begin
              cmd_o.wr_rule = 1'b1;
            end
            state_d = S_FINISH;
          end
          default: begin
            cmd_o.status = STS_UNKNOWN;
            state_d      = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.walk_step = 1'b1;
        priority if (sts_i.scan_hit) begin
          cmd_o.res_hit = 1'b1;
          state_d       = S_FINISH;
        end else if (sts_i.walk_end) begin
          state_d = S_FINISH;
        end
      end
      S_SHIFT: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_end) begin
          if (sts_i.act == ACT_ADD) begin
            cmd_o.wr_rule = 1'b1;
            cmd_o.cnt_inc = 1'b1;
          end else begin
            cmd_o.cnt_dec = 1'b1;
          end
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/static_nat_rule_table.sv @@
// ---------------------------------------------------------------------------
// static_nat_rule_table
// ordered static NAT table with first-match lookup and positional editing
// ---------------------------------------------------------------------------
// Each input transfer carries one action and yields exactly one result
// transfer. The rules sit in a single memory with one read and one write port,
// so lookups, adds and deletes walk it one entry per cycle: a lookup stops at
// the first hit or reads every rule held; an add moves every rule behind the
// insertion point up by one and a delete moves every rule behind the removed
// one down by one; modify, table-full, no-such-rule and unknown actions do not
// walk the memory. The block works on one item at a time, but the result sits
// in an output register, so the next item is taken while an earlier result
// still waits for its transfer. Rules live only in the memory and are never
// cleared: the count, reset to zero, decides which entries are live.
// ---------------------------------------------------------------------------
`include "static_nat_rule_table_macros.svh"

module static_nat_rule_table import snrt_pkg::*; #(
  parameter int unsigned MAX_RULES = MaxRulesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         action_i,
  input  logic signed [15:0] position_i,
  input  logic [7:0]         protocol_i,
  input  logic [31:0]        packet_addr_i,
  input  logic [15:0]        packet_port_i,
  input  logic [31:0]        inside_addr_i,
  input  logic [15:0]        inside_port_i,
  input  logic [31:0]        outside_addr_i,
  input  logic [15:0]        outside_port_i,
  input  logic               allow_tcp_i,
  input  logic               allow_udp_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               translated_o,
  output logic [31:0]        result_addr_o,
  output logic [15:0]        result_port_o,
  output logic [1:0]         status_o,
  output logic [TotalW-1:0]  rule_total_o
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: decode, scan or shift walk, then result hand-off
  snrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: rule memory, walk pointer, compare and result registers
  snrt_datapath #(
    .MaxRules(MAX_RULES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action_i),
    .position_i    (position_i),
    .protocol_i    (protocol_i),
    .packet_addr_i (packet_addr_i),
    .packet_port_i (packet_port_i),
    .inside_addr_i (inside_addr_i),
    .inside_port_i (inside_port_i),
    .outside_addr_i(outside_addr_i),
    .outside_port_i(outside_port_i),
    .allow_tcp_i   (allow_tcp_i),
    .allow_udp_i   (allow_udp_i),
    .translated_o  (translated_o),
    .result_addr_o (result_addr_o),
    .result_port_o (result_port_o),
    .status_o      (status_o),
    .rule_total_o  (rule_total_o)
  );

  // one item in flight: a taken item closes the input until it is done
  `SNRT_ASSERT_NXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)
  // a hit is only ever reported together with a good status
  `SNRT_ASSERT_IMP(a_hit_is_done, out_valid_o && translated_o, status_o == STS_DONE)
  // a full report means the table really holds the maximum
  `SNRT_ASSERT_IMP(a_full_count, out_valid_o && status_o == STS_FULL,
                   rule_total_o == TotalW'(MAX_RULES))

endmodule

@@ sim/static_nat_rule_table_checker.sv @@
// ---------------------------------------------------------------------------
// static NAT rule table checker
// watches both channels, keeps its own copy of the rule list, predicts one
// result per item transfer and compares every result transfer against it
// ---------------------------------------------------------------------------
module static_nat_rule_table_checker import snrt_pkg::*; #(
  parameter int unsigned MAX_RULES = MaxRulesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         action_i,
  input  logic signed [15:0] position_i,
  input  logic [7:0]         protocol_i,
  input  logic [31:0]        packet_addr_i,
  input  logic [15:0]        packet_port_i,
  input  logic [31:0]        inside_addr_i,
  input  logic [15:0]        inside_port_i,
  input  logic [31:0]        outside_addr_i,
  input  logic [15:0]        outside_port_i,
  input  logic               allow_tcp_i,
  input  logic               allow_udp_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               translated_i,
  input  logic [31:0]        result_addr_i,
  input  logic [15:0]        result_port_i,
  input  logic [1:0]         status_i,
  input  logic [TotalW-1:0]  rule_total_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 held_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]         act;
    logic signed [15:0] pos;
    logic [7:0]         proto;
    logic [31:0]        pkt_addr;
    logic [15:0]        pkt_port;
    logic [31:0]        in_addr;
    logic [15:0]        in_port;
    logic [31:0]        out_addr;
    logic [15:0]        out_port;
    logic               tcp;
    logic               udp;
  } nat_req_t;

  typedef struct packed {
    logic              hit;
    logic [31:0]       addr;
    logic [15:0]       port;
    status_e           status;
    logic [TotalW-1:0] total;
  } nat_result_t;

  rule_t       rules_q[$];
  nat_result_t results_due_q[$];
  nat_result_t want;
  int          err_cnt = 0;

  function automatic logic enabled_for(input logic [7:0] proto, input logic [1:0] en);
    return (proto == PROTO_TCP && en[0]) || (proto == PROTO_UDP && en[1]);
  endfunction

  // zero-based rule a position points at, -1 for none
  function automatic int pick_rule(input logic signed [15:0] pos);
    int p;
    p = int'(pos);
    if (rules_q.size() == 0) return -1;
    if (p <= 1) return 0;
    if (p <= rules_q.size()) return p - 1;
    return -1;
  endfunction

  function automatic nat_result_t apply_nat_item(input nat_req_t rq);
    nat_result_t r;
    rule_t       fresh;
    int          sel;
    r     = '{hit: 1'b0, addr: '0, port: '0, status: STS_DONE, total: '0};
    fresh = '{in_addr: rq.in_addr, in_port: rq.in_port, out_addr: rq.out_addr,
              out_port: rq.out_port, en: {rq.udp, rq.tcp}};
    case (rq.act)
      ACT_OUTBOUND, ACT_INBOUND: begin
        r.addr = rq.pkt_addr;
        r.port = rq.pkt_port;
        foreach (rules_q[i]) begin
          if (!r.hit && enabled_for(rq.proto, rules_q[i].en)) begin
            if (rq.act == ACT_OUTBOUND && rules_q[i].in_addr == rq.pkt_addr &&
                rules_q[i].in_port == rq.pkt_port) begin
              r.hit  = 1'b1;
              r.addr = rules_q[i].out_addr;
              r.port = rules_q[i].out_port;
            end else if (rq.act == ACT_INBOUND && rules_q[i].out_addr == rq.pkt_addr &&
                         rules_q[i].out_port == rq.pkt_port) begin
              r.hit  = 1'b1;
              r.addr = rules_q[i].in_addr;
              r.port = rules_q[i].in_port;
            end
          end
        end
      end
      ACT_ADD: begin
        if (rules_q.size() >= MAX_RULES) begin
          r.status = STS_FULL;
        end else begin
          sel = pick_rule(rq.pos);
          rules_q.insert((sel < 0) ? 0 : sel + 1, fresh);
        end
      end
      ACT_DELETE: begin
        sel = pick_rule(rq.pos);
        if (sel < 0) r.status = STS_NO_RULE;
        else rules_q.delete(sel);
      end
      ACT_MODIFY: begin
        sel = pick_rule(rq.pos);
        if (sel < 0) r.status = STS_NO_RULE;
        else rules_q[sel] = fresh;
      end
      default: r.status = STS_UNKNOWN;
    endcase
    r.total = TotalW'(rules_q.size());
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rules_q.delete();
      results_due_q.delete();
      pending_o <= 0;
      held_o    <= 0;
      errors_o  <= 0;
    end else begin
      // result side first: a result never belongs to an item taken in the same cycle
      if (out_valid_i && out_ready_i) begin
        if (results_due_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          err_cnt++;
        end else begin
          want = results_due_q.pop_front();
          check_field("translated", 32'(want.hit), 32'(translated_i));
          check_field("result_addr", want.addr, result_addr_i);
          check_field("result_port", 32'(want.port), 32'(result_port_i));
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("rule_total", 32'(want.total), 32'(rule_total_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        results_due_q.push_back(apply_nat_item('{
          act: action_i, pos: position_i, proto: protocol_i,
          pkt_addr: packet_addr_i, pkt_port: packet_port_i,
          in_addr: inside_addr_i, in_port: inside_port_i,
          out_addr: outside_addr_i, out_port: outside_port_i,
          tcp: allow_tcp_i, udp: allow_udp_i}));
      end
      pending_o <= results_due_q.size();
      held_o    <= rules_q.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

@@ sim/static_nat_rule_table_tb.sv @@
// ---------------------------------------------------------------------------
// static NAT rule table testbench
// directed edits and lookups on a small table, then random traffic that
// repeatedly fills the table to its limit and empties it again, with random
// gaps on the item side and random stalls on the result side
// ---------------------------------------------------------------------------
module static_nat_rule_table_tb import snrt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1830;
  localparam int EPOCH_LEN    = 130;   // items per traffic mix before switching
  localparam int SETTLE_WAIT  = 200;   // well beyond a full-table scan or shift

  // action codes the block does not know
  localparam logic [2:0] ACT_UNUSED_LO = 3'(ACT_MODIFY) + 3'd1;
  localparam logic [2:0] ACT_UNUSED_HI = '1;

  typedef enum logic [1:0] {
    MODE_GROW,
    MODE_MIX,
    MODE_SHRINK
  } gen_mode_e;

  typedef struct packed {
    logic [2:0]         act;
    logic signed [15:0] pos;
    logic [7:0]         proto;
    logic [31:0]        pkt_addr;
    logic [15:0]        pkt_port;
    logic [31:0]        in_addr;
    logic [15:0]        in_port;
    logic [31:0]        out_addr;
    logic [15:0]        out_port;
    logic               tcp;
    logic               udp;
  } nat_req_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         action_i;
  logic signed [15:0] position_i;
  logic [7:0]         protocol_i;
  logic [31:0]        packet_addr_i;
  logic [15:0]        packet_port_i;
  logic [31:0]        inside_addr_i;
  logic [15:0]        inside_port_i;
  logic [31:0]        outside_addr_i;
  logic [15:0]        outside_port_i;
  logic               allow_tcp_i;
  logic               allow_udp_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               translated_o;
  logic [31:0]        result_addr_o;
  logic [15:0]        result_port_o;
  logic [1:0]         status_o;
  logic [TotalW-1:0]  rule_total_o;

  int          mismatches;
  int          results_owed;
  int          rules_held;      // checker's rule count, one item behind at most
  logic        steady;          // no gaps and no stalls while set
  int unsigned cycle_cnt = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  static_nat_rule_table u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .position_i     (position_i),
    .protocol_i     (protocol_i),
    .packet_addr_i  (packet_addr_i),
    .packet_port_i  (packet_port_i),
    .inside_addr_i  (inside_addr_i),
    .inside_port_i  (inside_port_i),
    .outside_addr_i (outside_addr_i),
    .outside_port_i (outside_port_i),
    .allow_tcp_i    (allow_tcp_i),
    .allow_udp_i    (allow_udp_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .translated_o   (translated_o),
    .result_addr_o  (result_addr_o),
    .result_port_o  (result_port_o),
    .status_o       (status_o),
    .rule_total_o   (rule_total_o)
  );

  static_nat_rule_table_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .action_i       (action_i),
    .position_i     (position_i),
    .protocol_i     (protocol_i),
    .packet_addr_i  (packet_addr_i),
    .packet_port_i  (packet_port_i),
    .inside_addr_i  (inside_addr_i),
    .inside_port_i  (inside_port_i),
    .outside_addr_i (outside_addr_i),
    .outside_port_i (outside_port_i),
    .allow_tcp_i    (allow_tcp_i),
    .allow_udp_i    (allow_udp_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .translated_i   (translated_o),
    .result_addr_i  (result_addr_o),
    .result_port_i  (result_port_o),
    .status_i       (status_o),
    .rule_total_i   (rule_total_o),
    .errors_o       (mismatches),
    .pending_o      (results_owed),
    .held_o         (rules_held)
  );

  // result side back-pressure: outside the steady window, ready is low with a chance of 15 in a hundred
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 15);
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // small pools so that rules collide and lookups hit; sometimes a fully random value
  function automatic logic [31:0] pick_addr();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0A00_0001;
      3:       return 32'hC0A8_0101;
      4:       return 32'h0A00_0002;
      5:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'd80;
      3:       return 16'd443;
      4:       return 16'd53;
      5:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly positions in and just past the live range, some negative, some anything
  function automatic logic signed [15:0] pick_position(input int n);
    int r;
    r = $urandom_range(99);
    if (r < 60) return 16'($urandom_range(n + 1));
    if (r < 72) return 16'(n + 1 + int'($urandom_range(3)));
    if (r < 82) return 16'(-int'($urandom_range(3)));
    return 16'($urandom);
  endfunction

  function automatic nat_req_t lookup_req(input logic [2:0] act, input logic [7:0] proto,
                                          input logic [31:0] addr, input logic [15:0] port);
    return '{act: act, pos: '0, proto: proto, pkt_addr: addr, pkt_port: port,
             in_addr: '0, in_port: '0, out_addr: '0, out_port: '0, tcp: 1'b0, udp: 1'b0};
  endfunction

  function automatic nat_req_t rule_req(input logic [2:0] act, input logic signed [15:0] pos,
                                        input logic [31:0] iaddr, input logic [15:0] iport,
                                        input logic [31:0] oaddr, input logic [15:0] oport,
                                        input logic tcp, input logic udp);
    return '{act: act, pos: pos, proto: '0, pkt_addr: '0, pkt_port: '0,
             in_addr: iaddr, in_port: iport, out_addr: oaddr, out_port: oport,
             tcp: tcp, udp: udp};
  endfunction

  // every field random; the action mix depends on whether the table should grow or shrink
  function automatic nat_req_t random_req(input gen_mode_e mode, input int n);
    nat_req_t rq;
    int       r;
    int       add_lim;
    int       del_lim;
    case (mode)
      MODE_GROW:   begin add_lim = 75; del_lim = 78; end
      MODE_SHRINK: begin add_lim = 10; del_lim = 70; end
      default:     begin add_lim = 28; del_lim = 44; end
    endcase
    r = $urandom_range(99);
    if (r < 3) rq.act = ACT_UNUSED_LO + 3'($urandom_range(2));
    else if (r < add_lim) rq.act = ACT_ADD;
    else if (r < del_lim) rq.act = ACT_DELETE;
    else if (r < del_lim + 8) rq.act = ACT_MODIFY;
    else if (r[0]) rq.act = ACT_OUTBOUND;
    else rq.act = ACT_INBOUND;
    rq.pos = pick_position(n);
    r = $urandom_range(99);
    rq.proto    = (r < 40) ? PROTO_TCP : (r < 80) ? PROTO_UDP : 8'($urandom);
    rq.pkt_addr = pick_addr();
    rq.pkt_port = pick_port();
    rq.in_addr  = pick_addr();
    rq.in_port  = pick_port();
    rq.out_addr = pick_addr();
    rq.out_port = pick_port();
    rq.tcp      = 1'($urandom);
    rq.udp      = 1'($urandom);
    return rq;
  endfunction

  // present one item and hold it until the transfer; random gaps before it
  task automatic put_item(input nat_req_t rq);
    while (!steady && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= rq.act;
    position_i     <= rq.pos;
    protocol_i     <= rq.proto;
    packet_addr_i  <= rq.pkt_addr;
    packet_port_i  <= rq.pkt_port;
    inside_addr_i  <= rq.in_addr;
    inside_port_i  <= rq.in_port;
    outside_addr_i <= rq.out_addr;
    outside_port_i <= rq.out_port;
    allow_tcp_i    <= rq.tcp;
    allow_udp_i    <= rq.udp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // hold off the item side until every outstanding result has come back
  task automatic wait_results_home();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_owed != 0);
  endtask

  initial begin
    gen_mode_e mode;
    rst_ni         <= 1'b0;
    steady         <= 1'b0;
    in_valid_i     <= 1'b0;
    action_i       <= '0;
    position_i     <= '0;
    protocol_i     <= '0;
    packet_addr_i  <= '0;
    packet_port_i  <= '0;
    inside_addr_i  <= '0;
    inside_port_i  <= '0;
    outside_addr_i <= '0;
    outside_port_i <= '0;
    allow_tcp_i    <= 1'b0;
    allow_udp_i    <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: lookup passes through, edits find no rule
    put_item(lookup_req(ACT_OUTBOUND, PROTO_TCP, 32'h0A00_0001, 16'd80));
    put_item(rule_req(ACT_DELETE, 16'sd1, '0, '0, '0, '0, 1'b0, 1'b0));
    put_item(rule_req(ACT_MODIFY, 16'sh8000, '0, '0, '0, '0, 1'b1, 1'b1));
    // first add on an empty table, then a position past the end goes to the front
    put_item(rule_req(ACT_ADD, 16'sd0, 32'h0A00_0001, 16'd80, 32'hC633_6401, 16'd8080,
                      1'b1, 1'b0));
    put_item(rule_req(ACT_ADD, 16'sd32767, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF,
                      1'b1, 1'b1));
    // position one and below both insert right after the first rule
    put_item(rule_req(ACT_ADD, 16'sd1, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000, 16'h0000,
                      1'b0, 1'b1));
    put_item(rule_req(ACT_ADD, -16'sd1, 32'h0A00_0001, 16'd80, 32'h0B00_0001, 16'd443,
                      1'b1, 1'b1));
    // position equal to the count appends; this rule has both protocols off
    put_item(rule_req(ACT_ADD, 16'sd4, 32'h0102_0304, 16'd1, 32'h0506_0708, 16'd2,
                      1'b0, 1'b0));
    // duplicate inside pairs: the earlier rule must win for both tcp and udp
    put_item(lookup_req(ACT_OUTBOUND, PROTO_TCP, 32'h0A00_0001, 16'd80));
    put_item(lookup_req(ACT_OUTBOUND, PROTO_UDP, 32'h0A00_0001, 16'd80));
    put_item(lookup_req(ACT_INBOUND, PROTO_TCP, 32'hFFFF_FFFF, 16'hFFFF));
    put_item(lookup_req(ACT_INBOUND, PROTO_UDP, 32'h0000_0000, 16'h0000));
    // neither tcp nor udp never matches, and neither does a disabled rule
    put_item(lookup_req(ACT_OUTBOUND, 8'hFF, 32'h0A00_0001, 16'd80));
    put_item(lookup_req(ACT_OUTBOUND, 8'h00, 32'h0000_0000, 16'h0000));
    put_item(lookup_req(ACT_OUTBOUND, PROTO_TCP, 32'h0102_0304, 16'd1));
    // modify with all-ones content, then past the end
    put_item(rule_req(ACT_MODIFY, 16'sd2, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                      1'b1, 1'b1));
    put_item(rule_req(ACT_MODIFY, 16'sd6, '0, '0, '0, '0, 1'b0, 1'b0));
    put_item(lookup_req(ACT_INBOUND, PROTO_UDP, 32'hFFFF_FFFF, 16'hFFFF));
    put_item(rule_req(ACT_UNUSED_LO, 16'sd1, '0, '0, '0, '0, 1'b1, 1'b1));
    put_item(rule_req(ACT_UNUSED_HI, 16'sd1, '0, '0, '0, '0, 1'b1, 1'b1));
    // delete the first, the last, then positions that now select nothing
    put_item(rule_req(ACT_DELETE, 16'sh8000, '0, '0, '0, '0, 1'b0, 1'b0));
    put_item(rule_req(ACT_DELETE, 16'sd4, '0, '0, '0, '0, 1'b0, 1'b0));
    put_item(rule_req(ACT_DELETE, 16'sd4, '0, '0, '0, '0, 1'b0, 1'b0));
    put_item(rule_req(ACT_DELETE, 16'sd32767, '0, '0, '0, '0, 1'b0, 1'b0));
    wait_results_home();

    // random traffic: grow to full, churn, shrink to empty, over and over
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      mode = gen_mode_e'((i / EPOCH_LEN) % 3);
      steady <= (i >= 900 && i < 1100);
      if (i % 450 == 449) wait_results_home();
      put_item(random_req(mode, rules_held));
    end
    steady <= 1'b0;
    wait_results_home();
    // let any stray result show up before the verdict
    repeat (SETTLE_WAIT) @(posedge clk_i);

    if (mismatches == 0 && results_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
